// ===== hdl/uer_pkg.sv =====
// Shared types and constants for the three-channel ultrasonic echo ranger.
package uer_pkg;

  localparam int TickCountBits = 24;
  localparam int NumSensors    = 3;
  localparam int SensorBits    = 2;
  localparam int CmBits        = 16;
  localparam int TrigBits      = 10;
  localparam int HoldoffBits   = 20;
  localparam int ScaleBits     = 16;
  localparam int CfgIdxBits    = 2;
  localparam int CfgDataBits   = 20;

  localparam logic [TrigBits-1:0]    TrigReset    = TrigBits'(10);
  localparam logic [HoldoffBits-1:0] HoldoffReset = HoldoffBits'(60000);
  localparam logic [ScaleBits-1:0]   ScaleReset   = ScaleBits'(1115);

  typedef enum logic [1:0] {
    PhHoldoff = 2'd0,
    PhTrigger = 2'd1,
    PhWait    = 2'd2,
    PhMeasure = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgTrigger = 2'd0,
    CfgHoldoff = 2'd1,
    CfgScale   = 2'd2,
    CfgNone    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    UpdNone  = 2'd0,
    UpdFront = 2'd1,
    UpdLeft  = 2'd2,
    UpdRight = 2'd3
  } upd_e;

  // Sequencer result for one tick.
  typedef struct packed {
    logic [2:0]               trig;
    logic                     done;
    logic [SensorBits-1:0]    sensor;
    logic [TickCountBits-1:0] count;
  } seq_out_t;

endpackage

// ===== hdl/ultrasonic_echo_ranger_3ch.sv =====
// Three-channel ultrasonic echo ranger: handshake, config registers, result register.
// An accepted tick item passes the input register and then the result register.
// Throughput: one tick item per cycle unless a result is stalled; the sequencer step and
// distance scaling (one 24x16 multiply and compare) lie between the two registers.
// Reset: sequencer in holdoff for the front sensor with count 0, distances 0,
// config registers at 10 / 60000 / 1115 trigger, holdoff and scale.
module ultrasonic_echo_ranger_3ch (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            echo_front_i,
  input  logic                            echo_left_i,
  input  logic                            echo_right_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            trigger_front_o,
  output logic                            trigger_left_o,
  output logic                            trigger_right_o,
  output logic [uer_pkg::CmBits-1:0]      front_cm_o,
  output logic [uer_pkg::CmBits-1:0]      left_cm_o,
  output logic [uer_pkg::CmBits-1:0]      right_cm_o,
  output logic [1:0]                      updated_sensor_o,
  input  logic                            cfg_we_i,
  input  logic [uer_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [uer_pkg::CfgDataBits-1:0] cfg_data_i
);
  import uer_pkg::*;

  logic [TrigBits-1:0]    trig_ticks_q;
  logic [HoldoffBits-1:0] holdoff_q;
  logic [ScaleBits-1:0]   scale_q;

  logic       a_valid_q;
  logic [2:0] echo_q;
  logic       out_valid_q;
  logic       move;
  logic       step;
  logic       in_accept;

  seq_out_t          seq;
  logic [CmBits-1:0] dist_cm [3];
  upd_e              upd;

  logic [2:0]        trig_q;
  logic [CmBits-1:0] cm_q [3];
  upd_e              upd_q;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TrigReset;
      holdoff_q    <= HoldoffReset;
      scale_q      <= ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTrigger: trig_ticks_q <= cfg_data_i[TrigBits-1:0];
        CfgHoldoff: holdoff_q    <= cfg_data_i[HoldoffBits-1:0];
        CfgScale:   scale_q      <= cfg_data_i[ScaleBits-1:0];
        default:    ;
      endcase
    end
  end

  assign move       = !out_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !move;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign step       = a_valid_q && move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid_q <= 1'b1;
      end else if (move) begin
        a_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      echo_q <= {echo_right_i, echo_left_i, echo_front_i};
    end
    if (step) begin
      trig_q <= seq.trig;
      for (int i = 0; i < 3; i++) begin
        cm_q[i] <= dist_cm[i];
      end
      upd_q <= upd;
    end
  end

  uer_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .echo_i          (echo_q),
    .trigger_ticks_i (trig_ticks_q),
    .holdoff_ticks_i (holdoff_q),
    .seq_o           (seq)
  );

  uer_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .seq_i       (seq),
    .scale_q16_i (scale_q),
    .dist_o      (dist_cm),
    .upd_o       (upd)
  );

  assign out_valid_o      = out_valid_q;
  assign trigger_front_o  = trig_q[0];
  assign trigger_left_o   = trig_q[1];
  assign trigger_right_o  = trig_q[2];
  assign front_cm_o       = cm_q[0];
  assign left_cm_o        = cm_q[1];
  assign right_cm_o       = cm_q[2];
  assign updated_sensor_o = upd_q;

`ifndef SYNTH
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !move |=> a_valid_q)
    else $error("pending item lost under stall");
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed item did not reach result register");
  a_upd_has_trig_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && upd != UpdNone |-> seq.trig == 3'b000)
    else $error("distance update during trigger");
`endif

endmodule

// ===== hdl/uer_seq.sv =====
// Round-robin ranging sequencer: phase, current sensor and tick counter.
module uer_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [2:0]                   echo_i,
  input  logic [uer_pkg::TrigBits-1:0]    trigger_ticks_i,
  input  logic [uer_pkg::HoldoffBits-1:0] holdoff_ticks_i,
  output uer_pkg::seq_out_t            seq_o
);
  import uer_pkg::*;

  localparam logic [TickCountBits-1:0] CountMax = '1;

  phase_e                   phase_q, phase_d;
  logic [SensorBits-1:0]    sensor_q, sensor_d;
  logic [TickCountBits-1:0] count_q, count_d;
  logic [TickCountBits-1:0] count_inc;
  logic                     count_sat;
  logic                     echo_cur;
  logic [TrigBits-1:0]      trig_len;
  logic [2:0]               sensor_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHoldoff;
      sensor_q <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      sensor_q <= sensor_d;
      count_q  <= count_d;
    end
  end

  assign count_sat  = (count_q == CountMax);
  assign count_inc  = count_sat ? count_q : count_q + TickCountBits'(1);
  assign trig_len   = (trigger_ticks_i == '0) ? TrigBits'(1) : trigger_ticks_i;
  assign sensor_nxt = {1'b0, sensor_q} + 3'd1;

  always_comb begin
    unique case (sensor_q)
      2'd0:    echo_cur = echo_i[0];
      2'd1:    echo_cur = echo_i[1];
      2'd2:    echo_cur = echo_i[2];
      default: echo_cur = 1'b0;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    sensor_d    = sensor_q;
    count_d     = count_q;
    seq_o.trig  = '0;
    seq_o.done  = 1'b0;
    seq_o.sensor = sensor_q;
    seq_o.count  = count_q;
    unique case (phase_q)
      PhHoldoff: begin
        count_d = count_inc;
        if (32'(count_inc) >= 32'(holdoff_ticks_i) || count_inc == CountMax) begin
          phase_d  = PhTrigger;
          sensor_d = '0;
          count_d  = '0;
        end
      end
      PhTrigger: begin
        if (sensor_q != 2'd3) begin
          seq_o.trig[sensor_q] = 1'b1;
        end
        count_d = count_inc;
        if (32'(count_inc) >= 32'(trig_len) || count_inc == CountMax) begin
          phase_d = PhWait;
          count_d = '0;
        end
      end
      PhWait: begin
        if (echo_cur) begin
          phase_d = PhMeasure;
          count_d = TickCountBits'(1);
        end
      end
      PhMeasure: begin
        if (echo_cur) begin
          count_d = count_inc;
        end else begin
          seq_o.done = (sensor_q != 2'd3);
          count_d    = '0;
          if (32'(sensor_nxt) >= 32'(NumSensors)) begin
            sensor_d = '0;
            phase_d  = PhHoldoff;
          end else begin
            sensor_d = sensor_nxt[SensorBits-1:0];
            phase_d  = PhTrigger;
          end
        end
      end
      default: begin
        phase_d = PhHoldoff;
      end
    endcase
  end

`ifndef SYNTH
  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhWait |-> count_q == '0)
    else $error("count not zero while waiting for echo");
  a_meas_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhMeasure |-> count_q != '0)
    else $error("count zero during measurement");
  a_sensor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sensor_q) < 32'(NumSensors))
    else $error("sensor index out of range");
  a_trig_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(seq_o.trig))
    else $error("more than one trigger driven");
`endif

endmodule

// ===== hdl/uer_dist.sv =====
// Echo count to centimetre scaling and the stored distance per sensor.
module uer_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  uer_pkg::seq_out_t             seq_i,
  input  logic [uer_pkg::ScaleBits-1:0] scale_q16_i,
  output logic [uer_pkg::CmBits-1:0]    dist_o [3],
  output uer_pkg::upd_e                 upd_o
);
  import uer_pkg::*;

  localparam int ProdBits = TickCountBits + ScaleBits;

  logic [CmBits-1:0]   dist_q [3];
  logic [ProdBits-1:0] prod;
  logic [ProdBits-1:0] prod_sh;
  logic [CmBits-1:0]   cm;

  assign prod    = ProdBits'(seq_i.count) * ProdBits'(scale_q16_i);
  assign prod_sh = prod >> ScaleBits;
  assign cm      = (prod_sh > ProdBits'({CmBits{1'b1}})) ? '1 : prod_sh[CmBits-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dist_o[i] = dist_q[i];
    end
    upd_o = UpdNone;
    if (seq_i.done) begin
      dist_o[seq_i.sensor] = cm;
      upd_o = upd_e'(seq_i.sensor + SensorBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        dist_q[i] <= '0;
      end
    end else if (step_i) begin
      for (int i = 0; i < 3; i++) begin
        dist_q[i] <= dist_o[i];
      end
    end
  end

endmodule

// ===== verif/tb_ultrasonic_echo_ranger_3ch.sv =====
// Self-checking testbench for the three-channel ultrasonic echo ranger.
module tb_ultrasonic_echo_ranger_3ch;
  import uer_pkg::*;

  localparam logic [TickCountBits-1:0] CountMax = '1;
  localparam int QuietLimit = 5000;
  localparam int ShowLimit  = 60;

  typedef struct packed {
    logic [2:0]        trig;   // right, left, front
    logic [CmBits-1:0] front_cm;
    logic [CmBits-1:0] left_cm;
    logic [CmBits-1:0] right_cm;
    upd_e              upd;
  } range_res_t;

  // Tracks the ranging sequencer tick by tick and holds the results still owed.
  class range_scoreboard;
    logic [TrigBits-1:0]      trig_len;
    logic [HoldoffBits-1:0]   holdoff;
    logic [ScaleBits-1:0]     scale;
    phase_e                   ph;
    logic [SensorBits-1:0]    cur;
    logic [TickCountBits-1:0] count;
    logic [CmBits-1:0]        dist_cm [3];
    range_res_t               ranges_due [$];
    int unsigned              ticks_seen;
    int unsigned              updates_seen;
    int unsigned              errors;

    function new();
      trig_len     = TrigReset;
      holdoff      = HoldoffReset;
      scale        = ScaleReset;
      ph           = PhHoldoff;
      cur          = '0;
      count        = '0;
      foreach (dist_cm[i]) dist_cm[i] = '0;
      ticks_seen   = 0;
      updates_seen = 0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataBits-1:0] val);
      case (idx)
        CfgTrigger: trig_len = val[TrigBits-1:0];
        CfgHoldoff: holdoff  = val[HoldoffBits-1:0];
        CfgScale:   scale    = val[ScaleBits-1:0];
        default: ;
      endcase
    endfunction

    function logic [TickCountBits-1:0] bump(logic [TickCountBits-1:0] c);
      return (c == CountMax) ? c : c + 1'b1;
    endfunction

    function logic [CmBits-1:0] to_cm(logic [TickCountBits-1:0] c);
      logic [TickCountBits+ScaleBits-1:0] prod;
      prod = c * scale;
      prod = prod >> ScaleBits;
      return (prod > 65535) ? '1 : prod[CmBits-1:0];
    endfunction

    function int unsigned pending();
      return ranges_due.size();
    endfunction

    // One accepted tick item: advance the sequencer and queue its result.
    function void note_tick(logic [2:0] echo);
      range_res_t               r;
      logic                     e;
      logic [TickCountBits-1:0] len;
      r = '0;
      e = (cur < NumSensors) ? echo[cur] : 1'b0;
      case (ph)
        PhHoldoff: begin
          count = bump(count);
          if (count >= TickCountBits'(holdoff) || count == CountMax) begin
            ph    = PhTrigger;
            cur   = '0;
            count = '0;
          end
        end
        PhTrigger: begin
          // a zero length still gives a one-tick pulse
          len = (trig_len == '0) ? TickCountBits'(1) : TickCountBits'(trig_len);
          r.trig[cur] = 1'b1;
          count = bump(count);
          if (count >= len || count == CountMax) begin
            ph    = PhWait;
            count = '0;
          end
        end
        PhWait: begin
          if (e) begin
            ph    = PhMeasure;
            count = TickCountBits'(1);
          end
        end
        PhMeasure: begin
          if (e) begin
            count = bump(count);
          end else begin
            dist_cm[cur] = to_cm(count);
            r.upd        = upd_e'(cur + 2'd1);
            count        = '0;
            if (cur + 1 >= NumSensors) begin
              cur = '0;
              ph  = PhHoldoff;
            end else begin
              cur = cur + 1'b1;
              ph  = PhTrigger;
            end
          end
        end
      endcase
      r.front_cm = dist_cm[0];
      r.left_cm  = dist_cm[1];
      r.right_cm = dist_cm[2];
      ranges_due.push_back(r);
      ticks_seen++;
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= ShowLimit)
          $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        if (errors == ShowLimit)
          $display("%0t: further mismatches counted but not shown", $time);
      end
    endfunction

    function void check_result(range_res_t got);
      range_res_t want;
      if (ranges_due.size() == 0) begin
        errors++;
        if (errors <= ShowLimit)
          $display("%0t: result with nothing expected, expected none, got updated_sensor %0d",
                   $time, got.upd);
        return;
      end
      want = ranges_due.pop_front();
      compare("trigger_front", want.trig[0], got.trig[0]);
      compare("trigger_left", want.trig[1], got.trig[1]);
      compare("trigger_right", want.trig[2], got.trig[2]);
      compare("front_cm", want.front_cm, got.front_cm);
      compare("left_cm", want.left_cm, got.left_cm);
      compare("right_cm", want.right_cm, got.right_cm);
      compare("updated_sensor", want.upd, got.upd);
      if (got.upd != UpdNone) updates_seen++;
    endfunction
  endclass

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_stall_o;
  logic                   echo_front_i    = 1'b0;
  logic                   echo_left_i     = 1'b0;
  logic                   echo_right_i    = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i     = 1'b0;
  logic                   trigger_front_o;
  logic                   trigger_left_o;
  logic                   trigger_right_o;
  logic [CmBits-1:0]      front_cm_o;
  logic [CmBits-1:0]      left_cm_o;
  logic [CmBits-1:0]      right_cm_o;
  logic [1:0]             updated_sensor_o;
  logic                   cfg_we_i        = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i       = CfgTrigger;
  logic [CfgDataBits-1:0] cfg_data_i      = '0;

  range_scoreboard sb = new();

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_len       = 0;
  int          hold_token     = 0;
  int          token_seen     = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;
  int unsigned reg_writes     = 0;
  logic        wave_lvl  [3]  = '{1'b0, 1'b0, 1'b0};
  int unsigned wave_left [3]  = '{0, 0, 0};

  always #4 clk_i = ~clk_i;

  ultrasonic_echo_ranger_3ch u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .echo_front_i     (echo_front_i),
    .echo_left_i      (echo_left_i),
    .echo_right_i     (echo_right_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .trigger_front_o  (trigger_front_o),
    .trigger_left_o   (trigger_left_o),
    .trigger_right_o  (trigger_right_o),
    .front_cm_o       (front_cm_o),
    .left_cm_o        (left_cm_o),
    .right_cm_o       (right_cm_o),
    .updated_sensor_o (updated_sensor_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_token != token_seen) begin
      token_seen  <= hold_token;
      hold_left   <= hold_len;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    range_res_t seen;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_tick({echo_right_i, echo_left_i, echo_front_i});
      if (out_valid_o && !out_stall_i) begin
        seen.trig     = {trigger_right_o, trigger_left_o, trigger_front_o};
        seen.front_cm = front_cm_o;
        seen.left_cm  = left_cm_o;
        seen.right_cm = right_cm_o;
        seen.upd      = upd_e'(updated_sensor_o);
        sb.check_result(seen);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, QuietLimit, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic [2:0] echo);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    echo_front_i <= echo[0];
    echo_left_i  <= echo[1];
    echo_right_i <= echo[2];
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_run(input logic [2:0] echo, input int n);
    repeat (n) send_tick(echo);
  endtask

  // Wait until every owed result has come back; ends at a rising edge.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    reg_writes++;
  endtask

  task automatic shuffle_regs();
    write_reg(CfgTrigger, ($urandom_range(9) == 0) ? '0 : CfgDataBits'($urandom_range(12, 1)));
    write_reg(CfgHoldoff, CfgDataBits'($urandom_range(40, 0)));
    write_reg(CfgScale, CfgDataBits'($urandom_range(65535, 0)));
  endtask

  // Per-channel echo waveform: alternating low and high stretches, mostly short,
  // now and then a long echo, plus some pure noise ticks.
  function automatic logic [2:0] next_echo();
    logic [2:0] e;
    for (int ch = 0; ch < 3; ch++) begin
      if (wave_left[ch] == 0) begin
        wave_lvl[ch] = ~wave_lvl[ch];
        if (wave_lvl[ch])
          wave_left[ch] = ($urandom_range(19) == 0) ? $urandom_range(3000, 100)
                                                    : $urandom_range(40, 1);
        else
          wave_left[ch] = $urandom_range(20, 1);
      end
      wave_left[ch]--;
      e[ch] = wave_lvl[ch];
    end
    if ($urandom_range(99) < 8) e = 3'($urandom);
    return e;
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_tick(next_echo());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: still inside the long holdoff, echoes ignored
    send_run(3'b111, 6);
    send_run(3'b000, 4);
    drain();

    // trigger data masks to zero, zero holdoff, full scale, write to the spare index
    write_reg(CfgTrigger, 20'hFFC00);
    write_reg(CfgHoldoff, '0);
    write_reg(CfgScale, 20'h0FFFF);
    write_reg(CfgNone, 20'hA5A5A);

    // one hand-built round; off-sensor echoes toggle and must be ignored
    send_run(3'b000, 2);
    send_tick(3'b110);
    send_tick(3'b001);
    send_run(3'b111, 2);
    send_tick(3'b110);
    send_run(3'b010, 2);
    send_tick(3'b101);
    send_tick(3'b000);
    send_run(3'b100, 2);
    send_tick(3'b011);
    send_run(3'b000, 2);

    // long front echo at full scale
    send_run(3'b001, 400);
    send_tick(3'b000);
    drain();
    write_reg(CfgScale, '0);
    send_tick(3'b000);
    send_run(3'b010, 5);
    send_tick(3'b000);
    send_run(3'b100, 3);
    send_tick(3'b000);
    drain();

    // largest holdoff, then shrink it below the count already reached
    write_reg(CfgHoldoff, 20'hFFFFF);
    send_run(3'b111, 30);
    drain();
    write_reg(CfgHoldoff, 20'd5);
    write_reg(CfgScale, 20'd1115);
    run_phase(60, 0, 0);

    shuffle_regs();
    run_phase(130, 0, 0);
    shuffle_regs();
    run_phase(130, 84, 0);
    shuffle_regs();
    run_phase(130, 0, 84);
    shuffle_regs();
    run_phase(130, 29, 29);

    // longest trigger pulse
    write_reg(CfgTrigger, 20'd1023);
    write_reg(CfgHoldoff, '0);
    write_reg(CfgScale, CfgDataBits'($urandom_range(65535, 0)));
    run_phase(300, 0, 0);

    // output held off while ticks keep coming, so the input backs up
    shuffle_regs();
    @(negedge clk_i);
    hold_len   = 300;
    hold_token = hold_token + 1;
    @(posedge clk_i);
    run_phase(150, 0, 0);

    repeat (8) @(posedge clk_i);
    $display("%0d tick items checked, %0d distance updates, %0d register writes",
             sb.ticks_seen, sb.updates_seen, reg_writes);
    $display("covered reset settings, zero and max registers, "
             , "idle and stall mixes, output hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/uer_pkg.sv
hdl/uer_seq.sv
hdl/uer_dist.sv
hdl/ultrasonic_echo_ranger_3ch.sv
verif/tb_ultrasonic_echo_ranger_3ch.sv
